FILE: hdl/ptts_pkg.sv
// Shared types, codes and field layout of the periodic task tick scheduler.
`default_nettype none
package ptts_pkg;

  // Default sizes of the task table and the job store.
  localparam int MaxTasksDef = 8;
  localparam int MaxJobsDef  = 16;

  // Input item layout: command travels in tuser, the rest in tdata.
  localparam int InDataW = 72;
  localparam int InUserW = 2;
  // Output item layout, packed from bit 0 up.
  localparam int OutDataW = 88;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLICY     = 2'd0,
    CFG_TASK_COUNT = 2'd1,
    CFG_RSVD2      = 2'd2,
    CFG_RSVD3      = 2'd3
  } cfg_e;

  // Scheduling policies; the unused code behaves as deadline first.
  typedef enum logic [1:0] {
    POL_RM    = 2'd0,
    POL_EDF   = 2'd1,
    POL_LSF   = 2'd2,
    POL_EDF_B = 2'd3
  } policy_e;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DROP = 6'b000010,
    ST_REL  = 6'b000100,
    ST_PICK = 6'b001000,
    ST_RUN  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic in_drop;
    logic in_rel;
    logic in_pick;
    logic in_run;
    logic emit;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic scan_last;
    logic rel_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: hdl/ptts_rem.sv
// Bit-serial remainder unit: tells whether a 32-bit value is a multiple of a 16-bit one.
`default_nettype none
module ptts_rem
  import ptts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic        zero_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] dvd_q;
  logic [15:0] rem_q;
  logic [15:0] dsr_q;
  logic [16:0] trial;
  logic [16:0] diff;

  // One restoring step per cycle.
  assign trial = {rem_q, dvd_q[31]};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      rem_q <= diff[16] ? trial[15:0] : diff[15:0];
    end
  end

  assign done_o = done_q;
  assign zero_o = (rem_q == 16'd0);

endmodule
`default_nettype wire

FILE: hdl/ptts_ctrl.sv
// Tick sequencer: steps through drop, release, pick and run for each tick; other items go straight to emit.
`default_nettype none
module ptts_ctrl
  import ptts_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = stat_i.is_tick ? ST_DROP : ST_EMIT;
      end
      ST_DROP: begin
        if (stat_i.scan_last) state_d = ST_REL;
      end
      ST_REL: begin
        if (stat_i.rel_done) state_d = ST_PICK;
      end
      ST_PICK: begin
        if (stat_i.scan_last) state_d = ST_RUN;
      end
      ST_RUN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands to the datapath.
  assign in_ready_o     = (state_q == ST_IDLE);
  assign ctrl_o.accept  = (state_q == ST_IDLE) && in_valid_i;
  assign ctrl_o.in_drop = (state_q == ST_DROP);
  assign ctrl_o.in_rel  = (state_q == ST_REL);
  assign ctrl_o.in_pick = (state_q == ST_PICK);
  assign ctrl_o.in_run  = (state_q == ST_RUN);
  assign ctrl_o.emit    = (state_q == ST_EMIT) && stat_i.out_free;

endmodule
`default_nettype wire

FILE: hdl/ptts_dp.sv
// Scheduler datapath: task table, job store, scan logic and the result register.
`default_nettype none
module ptts_dp
  import ptts_pkg::*;
#(
  parameter int MAX_TASKS = MaxTasksDef,
  parameter int MAX_JOBS  = MaxJobsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  output stat_t               stat_o,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic [InUserW-1:0]  in_user_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  localparam int TW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TIW = $clog2(MAX_TASKS + 1);
  localparam int JW  = $clog2(MAX_JOBS);

  // Input fields.
  logic [2:0]  f_index;
  logic [15:0] f_phase, f_period, f_deadline, f_cost;
  logic [1:0]  f_cmd;
  assign f_index    = in_data_i[2:0];
  assign f_phase    = in_data_i[18:3];
  assign f_period   = in_data_i[34:19];
  assign f_deadline = in_data_i[50:35];
  assign f_cost     = in_data_i[66:51];
  assign f_cmd      = in_user_i;

  // Configuration registers.
  logic [1:0] policy_q;
  logic [3:0] tcount_q;

  // Task table.
  logic [15:0] t_phase_q [MAX_TASKS];
  logic [15:0] t_period_q[MAX_TASKS];
  logic [15:0] t_dl_q    [MAX_TASKS];
  logic [15:0] t_cost_q  [MAX_TASKS];

  // Job store.
  logic [MAX_JOBS-1:0] sv_q;
  logic [TIW-1:0]      s_task_q[MAX_JOBS];
  logic [31:0]         s_due_q [MAX_JOBS];
  logic [15:0]         s_left_q[MAX_JOBS];
  logic [31:0]         s_age_q [MAX_JOBS];

  // Run state.
  logic [31:0]   clock_q;
  logic          run_v_q;
  logic [JW-1:0] run_slot_q;
  logic          idle_rep_q;
  logic [31:0]   miss_q;
  logic [31:0]   seq_q;
  logic          is_tick_q;

  // Scan state.
  logic [JW-1:0]  sidx_q;
  logic [TIW-1:0] ti_q;
  logic           div_wait_q;
  logic           best_v_q;
  logic [JW-1:0]  best_slot_q;
  logic signed [33:0] best_key_q;
  logic [TIW-1:0] best_task_q;
  logic [31:0]    best_age_q;

  // Result fields of the item in work.
  logic [31:0] r_tick_q;
  logic [3:0]  r_run_q;
  logic        r_sw_q, r_idle_q, r_fin_q;
  logic [4:0]  r_miss_q;
  logic [3:0]  r_rel_q, r_ovf_q;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // One read port into the job store.
  logic [JW-1:0]  raddr;
  logic           r_valid;
  logic [TIW-1:0] r_task;
  logic [31:0]    r_due;
  logic [15:0]    r_left;
  logic [31:0]    r_age;
  assign raddr   = ctrl_i.in_run ? run_slot_q : sidx_q;
  assign r_valid = sv_q[raddr];
  assign r_task  = s_task_q[raddr];
  assign r_due   = s_due_q[raddr];
  assign r_left  = s_left_q[raddr];
  assign r_age   = s_age_q[raddr];

  // One read port into the task table.
  logic [TIW-1:0] task_m1;
  logic [TW-1:0]  taddr;
  logic [15:0]    tp_phase, tp_period, tp_dl, tp_cost;
  assign task_m1   = r_task - TIW'(1);
  assign taddr     = ctrl_i.in_pick ? task_m1[TW-1:0] : ti_q[TW-1:0];
  assign tp_phase  = t_phase_q[taddr];
  assign tp_period = t_period_q[taddr];
  assign tp_dl     = t_dl_q[taddr];
  assign tp_cost   = t_cost_q[taddr];

  // Tasks in use.
  logic [TIW-1:0] ntasks;
  assign ntasks = (int'(tcount_q) > MAX_TASKS) ? TIW'(MAX_TASKS) : TIW'(tcount_q);

  // Hopeless job test.
  logic drop_hit;
  assign drop_hit = r_valid && ({1'b0, r_due} < ({1'b0, clock_q} + {17'b0, r_left}));

  // Lowest free slot.
  logic          free_found;
  logic [JW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = MAX_JOBS - 1; j >= 0; j--) begin
      if (!sv_q[j]) begin
        free_found = 1'b1;
        free_idx   = JW'(j);
      end
    end
  end

  // Release check for task ti_q, using the remainder unit when needed.
  logic        rem_done, rem_zero, rem_start;
  logic        decide, rel_fire, rel_last, no_tasks;
  logic [31:0] since;
  logic [32:0] due_sum;
  logic [31:0] due_sat;
  assign since    = clock_q - {16'b0, tp_phase};
  assign no_tasks = (ntasks == '0);
  assign rel_last = (ti_q == ntasks - TIW'(1));
  always_comb begin
    decide    = 1'b0;
    rel_fire  = 1'b0;
    rem_start = 1'b0;
    if (ctrl_i.in_rel && !no_tasks) begin
      if (div_wait_q) begin
        decide   = rem_done;
        rel_fire = rem_zero;
      end else if (clock_q < {16'b0, tp_phase}) begin
        decide = 1'b1;
      end else if (tp_period == 16'd0) begin
        decide   = 1'b1;
        rel_fire = (clock_q == {16'b0, tp_phase});
      end else begin
        rem_start = 1'b1;
      end
    end
  end
  assign due_sum = {1'b0, clock_q} + {17'b0, tp_dl};
  assign due_sat = due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];

  ptts_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (since),
    .divisor_i  (tp_period),
    .done_o     (rem_done),
    .zero_o     (rem_zero)
  );

  logic do_rel, do_ovf;
  assign do_rel = decide && rel_fire && free_found;
  assign do_ovf = decide && rel_fire && !free_found;

  // Scheduling key and preference of the scanned slot.
  logic signed [33:0] key;
  logic               better;
  always_comb begin
    case (policy_e'(policy_q))
      POL_RM:  key = $signed({18'b0, tp_period});
      POL_LSF: key = $signed({2'b0, r_due}) - $signed({2'b0, clock_q})
                     - $signed({18'b0, r_left});
      default: key = $signed({2'b0, r_due});
    endcase
  end
  assign better = !best_v_q || (key < best_key_q) ||
                  ((key == best_key_q) && ((r_task < best_task_q) ||
                   ((r_task == best_task_q) && (r_age < best_age_q))));

  logic scan_last, pick_cand, pick_apply, new_v, run_fin;
  logic [JW-1:0] new_slot;
  assign scan_last  = (sidx_q == JW'(MAX_JOBS - 1));
  assign pick_cand  = ctrl_i.in_pick && r_valid && better;
  assign pick_apply = ctrl_i.in_pick && scan_last && ((r_rel_q != 4'd0) || !run_v_q);
  assign new_v      = best_v_q || pick_cand;
  assign new_slot   = pick_cand ? sidx_q : best_slot_q;
  assign run_fin    = r_left <= 16'd1;

  logic restart;
  assign restart = ctrl_i.accept && (cmd_e'(f_cmd) == CMD_RESTART);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= POL_EDF;
      tcount_q    <= '0;
      clock_q     <= '0;
      sv_q        <= '0;
      run_v_q     <= 1'b0;
      run_slot_q  <= '0;
      idle_rep_q  <= 1'b0;
      miss_q      <= '0;
      seq_q       <= '0;
      is_tick_q   <= 1'b0;
      sidx_q      <= '0;
      ti_q        <= '0;
      div_wait_q  <= 1'b0;
      best_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_POLICY:     policy_q <= cfg_data_i[1:0];
          CFG_TASK_COUNT: tcount_q <= cfg_data_i[3:0];
          default:        ;
        endcase
      end
      if (ctrl_i.accept) begin
        is_tick_q <= (cmd_e'(f_cmd) == CMD_TICK);
        sidx_q    <= '0;
        ti_q      <= '0;
        best_v_q  <= 1'b0;
      end
      if (restart) begin
        clock_q    <= '0;
        sv_q       <= '0;
        run_v_q    <= 1'b0;
        idle_rep_q <= 1'b0;
        miss_q     <= '0;
        seq_q      <= '0;
      end
      // Drop scan.
      if (ctrl_i.in_drop) begin
        sidx_q <= scan_last ? '0 : sidx_q + JW'(1);
        if (drop_hit) begin
          sv_q[sidx_q] <= 1'b0;
          if (miss_q != 32'hFFFF_FFFF) miss_q <= miss_q + 32'd1;
          if (run_v_q && (run_slot_q == sidx_q)) run_v_q <= 1'b0;
        end
      end
      // Releases, one task at a time.
      if (rem_start) div_wait_q <= 1'b1;
      if (decide) begin
        div_wait_q <= 1'b0;
        ti_q       <= rel_last ? '0 : ti_q + TIW'(1);
      end
      if (do_rel) begin
        sv_q[free_idx] <= 1'b1;
        if (seq_q != 32'hFFFF_FFFF) seq_q <= seq_q + 32'd1;
      end
      // Pick scan.
      if (ctrl_i.in_pick) begin
        sidx_q <= scan_last ? '0 : sidx_q + JW'(1);
        if (pick_cand) begin
          best_v_q    <= 1'b1;
          best_slot_q <= sidx_q;
        end
        if (pick_apply) begin
          run_v_q    <= new_v;
          run_slot_q <= new_slot;
        end
      end
      // Run one unit.
      if (ctrl_i.in_run) begin
        if (run_v_q) begin
          idle_rep_q <= 1'b0;
          if (run_fin) begin
            sv_q[run_slot_q] <= 1'b0;
            run_v_q          <= 1'b0;
          end
        end else if (!idle_rep_q) begin
          idle_rep_q <= 1'b1;
        end
        if (clock_q != 32'hFFFF_FFFF) clock_q <= clock_q + 32'd1;
      end
      // Result register.
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && (cmd_e'(f_cmd) == CMD_WRITE)) begin
      for (int t = 0; t < MAX_TASKS; t++) begin
        if (int'(f_index) == t) begin
          t_phase_q[t]  <= f_phase;
          t_period_q[t] <= f_period;
          t_dl_q[t]     <= f_deadline;
          t_cost_q[t]   <= f_cost;
        end
      end
    end
    if (do_rel) begin
      s_task_q[free_idx] <= ti_q + TIW'(1);
      s_due_q[free_idx]  <= due_sat;
      s_left_q[free_idx] <= tp_cost;
      s_age_q[free_idx]  <= seq_q;
    end
    if (pick_cand) begin
      best_key_q  <= key;
      best_task_q <= r_task;
      best_age_q  <= r_age;
    end
    if (ctrl_i.in_run && run_v_q) begin
      s_left_q[run_slot_q] <= run_fin ? 16'd0 : r_left - 16'd1;
    end
    // Result fields of the item in work.
    if (ctrl_i.accept) begin
      r_tick_q <= restart ? 32'd0 : clock_q;
      r_run_q  <= '0;
      r_sw_q   <= 1'b0;
      r_idle_q <= 1'b0;
      r_fin_q  <= 1'b0;
      r_miss_q <= '0;
      r_rel_q  <= '0;
      r_ovf_q  <= '0;
    end
    if (ctrl_i.in_drop && drop_hit) r_miss_q <= r_miss_q + 5'd1;
    if (do_rel) r_rel_q <= r_rel_q + 4'd1;
    if (do_ovf) r_ovf_q <= r_ovf_q + 4'd1;
    if (pick_apply && new_v && (!run_v_q || (run_slot_q != new_slot))) r_sw_q <= 1'b1;
    if (ctrl_i.in_run) begin
      if (run_v_q) begin
        r_run_q <= 4'(r_task);
        r_fin_q <= run_fin;
      end else if (!idle_rep_q) begin
        r_idle_q <= 1'b1;
      end
    end
    if (ctrl_i.emit) begin
      out_data_q <= {4'b0, miss_q, r_ovf_q, r_rel_q, r_miss_q,
                     r_fin_q, r_idle_q, r_sw_q, r_run_q, r_tick_q};
    end
  end

  assign stat_o.is_tick   = (cmd_e'(f_cmd) == CMD_TICK);
  assign stat_o.scan_last = scan_last;
  assign stat_o.rel_done  = ctrl_i.in_rel && (no_tasks || (decide && rel_last));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The running job always sits in a live slot.
  a_run_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_v_q |-> sv_q[run_slot_q])
    else $error("running job slot is not valid");

  // A tick that finished a job never reports going idle.
  a_fin_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q[38] && out_data_q[37]))
    else $error("job finished and went idle in one tick");

  // The miss counter only steps by one or restarts.
  a_miss_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (miss_q != $past(miss_q)) |-> ((miss_q == $past(miss_q) + 32'd1) || (miss_q == 32'd0)))
    else $error("miss counter jumped");

endmodule
`default_nettype wire

FILE: hdl/periodic_task_tick_scheduler_unit.sv
// Top level of the periodic task tick scheduler.
// Each input item is a command in tuser: a tick, a task table write, a
// restart of the run, or a no-op. A write, restart or no-op goes straight
// to the result. A tick goes through a drop scan, the release steps, a pick
// scan and a run step. When no task is in use the release step does nothing.
// Otherwise each task in use is decided directly when the clock is before
// its phase or its period is zero, and else goes through the one-bit-per-cycle
// remainder unit. One job slot is examined per cycle in the drop scan and
// again in the pick scan. One item is worked on at a time; the finished
// result waits in an output register while the next item is taken.
// Configuration writes are always accepted and are meant for idle periods.
`default_nettype none
module periodic_task_tick_scheduler_unit
  import ptts_pkg::*;
#(
  parameter int MAX_TASKS = MaxTasksDef,
  parameter int MAX_JOBS  = MaxJobsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0: task_index[2:0], phase[18:3], period[34:19],
  // deadline[50:35], exec_time[66:51], zero fill.
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Fields from bit 0: command[1:0].
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // Fields from bit 0: tick_time[31:0], running_task[35:32], switched[36],
  // went_idle[37], job_finished[38], missed_now[43:39], released_now[47:44],
  // overflowed_now[51:48], missed_total[83:52], zero fill.
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  ptts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ptts_dp #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_JOBS  (MAX_JOBS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_we_i    (cfg_valid_i),
    .cfg_idx_i   (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

FILE: tb/sv/tb_periodic_task_tick_scheduler_unit.sv
// Testbench of the periodic task tick scheduler: random task sets, ticks and checks.
`default_nettype none
module tb_periodic_task_tick_scheduler_unit;
  import ptts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumTasks  = 8;
  localparam int NumSlots  = 16;
  localparam int NoSlot    = NumSlots;
  localparam int StallLimit = 3000;
  localparam int RandItems = 1830;

  // Tracks the schedule the block should produce and checks each result.
  class sched_scoreboard;
    bit [1:0]  policy;
    bit [3:0]  task_count;
    bit [31:0] clock_now, miss_count, release_seq;
    bit [15:0] t_phase[NumTasks], t_period[NumTasks], t_dl[NumTasks], t_cost[NumTasks];
    bit        s_valid[NumSlots];
    int        s_task[NumSlots];
    bit [31:0] s_due[NumSlots], s_age[NumSlots];
    bit [15:0] s_left[NumSlots];
    int        run_slot;
    bit        idle_seen;
    bit [OutDataW-1:0] due_results[$];
    int        errors;

    function new();
      policy = POL_EDF;
      task_count = 0;
      errors = 0;
      restart_run();
    endfunction

    function void restart_run();
      clock_now = 0;
      miss_count = 0;
      release_seq = 0;
      run_slot = NoSlot;
      idle_seen = 0;
      foreach (s_valid[s]) s_valid[s] = 0;
    endfunction

    function void configure(cfg_e idx, bit [31:0] val);
      if (idx == CFG_POLICY) policy = val[1:0];
      else if (idx == CFG_TASK_COUNT) task_count = val[3:0];
    endfunction

    function longint slot_key(int s);
      if (policy == POL_RM) return longint'(t_period[s_task[s] - 1]);
      if (policy == POL_LSF)
        return longint'(s_due[s]) - longint'(clock_now) - longint'(s_left[s]);
      return longint'(s_due[s]);
    endfunction

    // True when slot a should run ahead of slot b.
    function bit prefer(int a, int b);
      longint ka, kb;
      ka = slot_key(a);
      kb = slot_key(b);
      if (ka != kb) return ka < kb;
      if (s_task[a] != s_task[b]) return s_task[a] < s_task[b];
      if (s_age[a] != s_age[b]) return s_age[a] < s_age[b];
      return a < b;
    endfunction

    function void note_item(bit [1:0] cmd, bit [InDataW-1:0] d);
      bit [OutDataW-1:0] res;
      int ntasks, s, best, missed, released, ovf, run_tid;
      bit sw, idle_now, fin, rel;
      bit [31:0] tick;
      longint unsigned due;
      res = '0;
      missed = 0; released = 0; ovf = 0; run_tid = 0;
      sw = 0; idle_now = 0; fin = 0;
      tick = clock_now;
      if (cmd != CMD_TICK) begin
        if (cmd == CMD_WRITE) begin
          t_phase[d[2:0]]  = d[18:3];
          t_period[d[2:0]] = d[34:19];
          t_dl[d[2:0]]     = d[50:35];
          t_cost[d[2:0]]   = d[66:51];
        end else if (cmd == CMD_RESTART) begin
          restart_run();
        end
        tick = clock_now;
      end else begin
        ntasks = (task_count < NumTasks) ? task_count : NumTasks;
        // Drop jobs that cannot meet their deadline any more.
        for (s = 0; s < NumSlots; s++) begin
          if (s_valid[s] && longint'(s_due[s]) < longint'(clock_now) + longint'(s_left[s]))
          begin
            s_valid[s] = 0;
            missed++;
            if (miss_count != '1) miss_count++;
            if (run_slot == s) run_slot = NoSlot;
          end
        end
        // Release jobs of tasks whose period lines up with the clock.
        for (int i = 0; i < ntasks; i++) begin
          if (clock_now < t_phase[i]) rel = 0;
          else if (t_period[i] == 0) rel = (clock_now == t_phase[i]);
          else rel = ((clock_now - t_phase[i]) % t_period[i]) == 0;
          if (rel) begin
            for (s = 0; s < NumSlots; s++) if (!s_valid[s]) break;
            if (s == NumSlots) begin
              ovf++;
            end else begin
              due = longint'(clock_now) + t_dl[i];
              s_valid[s] = 1;
              s_task[s] = i + 1;
              s_due[s] = (due > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : due[31:0];
              s_left[s] = t_cost[i];
              s_age[s] = release_seq;
              if (release_seq != '1) release_seq++;
              released++;
            end
          end
        end
        // Pick only on a release or when nothing runs.
        if (released > 0 || run_slot == NoSlot) begin
          best = NoSlot;
          for (s = 0; s < NumSlots; s++)
            if (s_valid[s] && (best == NoSlot || prefer(s, best))) best = s;
          if (best != run_slot) begin
            run_slot = best;
            sw = 1;
          end
        end
        // Run the chosen job for one unit.
        if (run_slot != NoSlot) begin
          run_tid = s_task[run_slot];
          if (s_left[run_slot] <= 1) begin
            s_left[run_slot] = 0;
            s_valid[run_slot] = 0;
            run_slot = NoSlot;
            fin = 1;
          end else begin
            s_left[run_slot]--;
          end
          idle_seen = 0;
        end else if (!idle_seen) begin
          idle_seen = 1;
          idle_now = 1;
        end
        if (clock_now != '1) clock_now++;
      end
      res[31:0]  = tick;
      res[35:32] = run_tid[3:0];
      res[36]    = sw;
      res[37]    = idle_now;
      res[38]    = fin;
      res[43:39] = missed[4:0];
      res[47:44] = released[3:0];
      res[51:48] = ovf[3:0];
      res[83:52] = miss_count;
      due_results.push_back(res);
    endfunction

    function void check_result(bit [OutDataW-1:0] got);
      bit [OutDataW-1:0] exp_r;
      string names[10] = '{"tick_time", "running_task", "switched", "went_idle",
                           "job_finished", "missed_now", "released_now",
                           "overflowed_now", "missed_total", "zero_fill"};
      int lsb[10] = '{0, 32, 36, 37, 38, 39, 44, 48, 52, 84};
      int wid[10] = '{32, 4, 1, 1, 1, 5, 4, 4, 32, 4};
      bit [31:0] e, a;
      if (due_results.size() == 0) begin
        $error("unexpected result item %h", got);
        errors++;
        return;
      end
      exp_r = due_results.pop_front();
      for (int f = 0; f < 10; f++) begin
        e = 32'((exp_r >> lsb[f]) & ((64'd1 << wid[f]) - 1));
        a = 32'((got >> lsb[f]) & ((64'd1 << wid[f]) - 1));
        if (e !== a) begin
          $error("%s: expected %0d, got %0d", names[f], e, a);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [InUserW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  sched_scoreboard sb = new();
  int idle_pct = 27;
  int stall_cnt = 0;
  int n_items = 0;

  periodic_task_tick_scheduler_unit u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Receiver stalls at random.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Result check and progress watchdog.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("[periodic_task_tick_scheduler_unit] ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send_item(cmd_e cmd, bit [2:0] idx = 0, bit [15:0] ph = 0,
                           bit [15:0] per = 0, bit [15:0] dl = 0, bit [15:0] cost = 0);
    bit [InDataW-1:0] d;
    d = '0;
    d[2:0] = idx;
    d[18:3] = ph;
    d[34:19] = per;
    d[50:35] = dl;
    d[66:51] = cost;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(cmd, d);
    n_items++;
  endtask

  // Let the block run dry before touching its registers.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_e idx, bit [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.configure(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // One task entry, mostly small values so jobs interact.
  task automatic write_random_task(bit [2:0] idx);
    if ($urandom_range(99) < 15)
      send_item(CMD_WRITE, idx, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    else
      send_item(CMD_WRITE, idx, 16'($urandom_range(15)),
                ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 40)),
                16'($urandom_range(1, 40)), 16'($urandom_range(0, 8)));
  endtask

  initial begin
    int nticks;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // Directed: all entries written, zero period, zero cost and field extremes.
    cfg_write(CFG_POLICY, 32'(POL_RM));
    cfg_write(CFG_TASK_COUNT, 8);
    send_item(CMD_RESTART);
    send_item(CMD_WRITE, 0, 0, 4, 4, 1);
    send_item(CMD_WRITE, 1, 1, 0, 3, 2);
    send_item(CMD_WRITE, 2, 0, 6, 6, 0);
    send_item(CMD_WRITE, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_WRITE, 4, 2, 1, 1, 1);
    send_item(CMD_WRITE, 5, 0, 3, 2, 3);
    send_item(CMD_WRITE, 6, 0, 5, 16'hFFFF, 7);
    send_item(CMD_WRITE, 7, 0, 2, 1, 2);
    for (int i = 0; i < 8; i++) send_item(CMD_TICK);
    send_item(CMD_NOP);
    send_item(CMD_TICK);

    // Random phases: configuration, restart, new tasks, then a burst of ticks.
    while (n_items < RandItems) begin
      if ($urandom_range(2) == 0 || n_items < 100) begin
        drain();
        cfg_write(CFG_POLICY, $urandom_range(3));
        cfg_write(CFG_TASK_COUNT, ($urandom_range(9) == 0) ? $urandom_range(9, 15)
                                                          : $urandom_range(8));
      end
      idle_pct = (n_items > 700 && n_items < 1000) ? 0 : 27;
      if ($urandom_range(9) != 0) send_item(CMD_RESTART);
      repeat ($urandom_range(1, 8)) write_random_task(3'($urandom_range(7)));
      nticks = $urandom_range(20, 120);
      for (int i = 0; i < nticks; i++) begin
        if ($urandom_range(49) == 0) send_item(cmd_e'($urandom_range(1, 3)),
                                               3'($urandom), 16'($urandom),
                                               16'($urandom), 16'($urandom),
                                               16'($urandom));
        else send_item(CMD_TICK);
      end
    end

    drain();
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("[periodic_task_tick_scheduler_unit] OK");
    end else begin
      $display("[periodic_task_tick_scheduler_unit] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
